// ===== hdl/afp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants of the actuator frame parser
// Holds the result status codes, the frame job record and the payload buffer
// write and release records.
// ----------------------------------------------------------------------------
package afp_pkg;

    localparam int MAX_PAYLOAD = 60;
    localparam int IDX_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int MEM_AW      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** MEM_AW;

    localparam logic [7:0] START_BYTE_RESET = 8'h3E;

    localparam logic [1:0] STATUS_GOOD = 2'd0;
    localparam logic [1:0] STATUS_CSUM = 2'd1;
    localparam logic [1:0] STATUS_LEN  = 2'd2;

    // One finished frame, handed from the front to the back.
    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] device_id;
        logic [IDX_W-1:0]  length;
        logic              use_mem;
        logic              bank;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

// ===== hdl/afp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_front: frame hunter and checker
// Parses the byte stream, writes payload bytes into one bank of the payload
// buffer and pushes one job per finished frame into the queue.
// ----------------------------------------------------------------------------
module afp_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         start_byte,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               q_full,
    output logic               push,
    output afp_pkg::job_t      push_job,
    output afp_pkg::mem_wr_t   mem_wr,
    input  afp_pkg::bank_rel_t bank_rel
);
    import afp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEAD, PH_CMD, PH_ID, PH_LEN, PH_HSUM, PH_DATA, PH_DSUM
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [7:0]        dev_reg, dev_next;
    logic [IDX_W-1:0]  len_reg, len_next;
    logic [7:0]        hrx_reg, hrx_next;
    logic [7:0]        dsum_reg, dsum_next;
    logic [IDX_W-1:0]  wpos_reg, wpos_next;
    logic              wbank_reg, wbank_next;
    logic [1:0]        busy_reg, busy_next;
    logic              s_fire;
    logic [7:0]        hdr_sum;

    assign s_ready = !q_full && !(phase_reg == PH_DATA && busy_reg[wbank_reg]);
    assign s_fire  = s_valid && s_ready;
    assign hdr_sum = start_byte + dev_reg + cmd_reg + {2'b00, len_reg};

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        dev_next   = dev_reg;
        len_next   = len_reg;
        hrx_next   = hrx_reg;
        dsum_next  = dsum_reg;
        wpos_next  = wpos_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        push       = 1'b0;
        push_job   = '0;
        mem_wr     = '0;
        push_job.command   = cmd_reg;
        push_job.device_id = dev_reg;
        push_job.length    = len_reg;
        push_job.bank      = wbank_reg;
        if (s_fire) begin
            unique case (phase_reg)
                PH_HEAD: begin
                    if (s_rx_byte == start_byte) phase_next = PH_CMD;
                end
                PH_CMD: begin
                    cmd_next   = s_rx_byte;
                    phase_next = PH_ID;
                end
                PH_ID: begin
                    dev_next   = s_rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if (s_rx_byte > 8'(MAX_PAYLOAD)) begin
                        push            = 1'b1;
                        push_job.status = STATUS_LEN;
                        push_job.length = s_rx_byte[IDX_W-1:0];
                        phase_next      = PH_HEAD;
                    end else begin
                        len_next   = s_rx_byte[IDX_W-1:0];
                        wpos_next  = '0;
                        dsum_next  = '0;
                        phase_next = PH_HSUM;
                    end
                end
                PH_HSUM: begin
                    hrx_next = s_rx_byte;
                    if (len_reg == '0) begin
                        push            = 1'b1;
                        push_job.status = (hdr_sum == s_rx_byte) ? STATUS_GOOD : STATUS_CSUM;
                        phase_next      = PH_HEAD;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    mem_wr.en   = 1'b1;
                    mem_wr.addr = {wbank_reg, wpos_reg};
                    mem_wr.data = s_rx_byte;
                    dsum_next   = dsum_reg + s_rx_byte;
                    if (({1'b0, wpos_reg} + 1'b1) >= {1'b0, len_reg}) begin
                        phase_next = PH_DSUM;
                    end else begin
                        wpos_next = wpos_reg + 1'b1;
                    end
                end
                PH_DSUM: begin
                    push       = 1'b1;
                    phase_next = PH_HEAD;
                    if (hdr_sum != hrx_reg || dsum_reg != s_rx_byte) begin
                        push_job.status = STATUS_CSUM;
                    end else begin
                        push_job.status  = STATUS_GOOD;
                        push_job.use_mem = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_HEAD;
                end
            endcase
        end
        if (bank_rel.valid) busy_next[bank_rel.bank] = 1'b0;
        if (push && push_job.use_mem) begin
            busy_next[wbank_reg] = 1'b1;
            wbank_next           = ~wbank_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEAD;
            cmd_reg   <= '0;
            dev_reg   <= '0;
            len_reg   <= '0;
            hrx_reg   <= '0;
            dsum_reg  <= '0;
            wpos_reg  <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            dev_reg   <= dev_next;
            len_reg   <= len_next;
            hrx_reg   <= hrx_next;
            dsum_reg  <= dsum_next;
            wpos_reg  <= wpos_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    // A bank that still feeds the back end is never overwritten.
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr.en |-> !busy_reg[mem_wr.addr[MEM_AW-1]])
        else $error("payload write into a busy bank");

    // Nothing is pushed into a full queue.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("job pushed while queue full");

    // The bank being filled is never claimed by a pending job once data flows.
    a_fill_bank_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && phase_reg == PH_DATA) |-> !busy_reg[wbank_reg])
        else $error("data byte taken into a busy bank");

endmodule

// ===== hdl/afp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_queue: two-entry job queue
// Decouples the frame parser from the result sequencer.
// ----------------------------------------------------------------------------
module afp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  afp_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output afp_pkg::job_t q_job
);
    import afp_pkg::*;

    job_t       slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_job   = slot_reg[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 2'd1;
        if (pop && !push) count_next = count_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== hdl/afp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afp_back: payload buffer and result sequencer
// Holds the two-bank payload buffer and turns each queued job into its
// result words: one per payload byte, or a single word for an error or an
// empty frame.
// ----------------------------------------------------------------------------
module afp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  afp_pkg::mem_wr_t     mem_wr,
    input  logic                 q_valid,
    input  afp_pkg::job_t        q_job,
    output logic                 pop,
    output afp_pkg::bank_rel_t   bank_rel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic [7:0]           m_command,
    output logic [7:0]           m_device_id,
    output logic [5:0]           m_length,
    output logic [7:0]           m_payload_byte,
    output logic [5:0]           m_payload_index,
    output logic                 m_last
);
    import afp_pkg::*;

    typedef struct packed {
        logic             valid;
        job_t             job;
        logic [IDX_W-1:0] idx;
        logic             last;
    } slot_t;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [MEM_AW-1:0] rd_addr;
    logic [IDX_W-1:0]  idx_reg;
    slot_t             p1_reg;
    logic              m_valid_reg;
    logic [1:0]        status_reg;
    logic [7:0]        command_reg, device_reg, pbyte_reg;
    logic [5:0]        length_reg, pindex_reg;
    logic              last_reg;
    logic              advance, p1_free, issue, issue_last;

    assign advance    = !m_valid_reg || m_ready;
    assign p1_free    = !p1_reg.valid || advance;
    assign issue      = q_valid && p1_free;
    assign issue_last = !q_job.use_mem || (idx_reg == (q_job.length - 1'b1));
    assign pop        = issue && issue_last;
    assign rd_addr    = p1_free ? {q_job.bank, idx_reg} : {p1_reg.job.bank, p1_reg.idx};

    assign bank_rel.valid = advance && p1_reg.valid && p1_reg.job.use_mem && p1_reg.last;
    assign bank_rel.bank  = p1_reg.job.bank;

    always_ff @(posedge aclk) begin
        if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg  <= p1_reg.job.status;
            command_reg <= p1_reg.job.command;
            device_reg  <= p1_reg.job.device_id;
            length_reg  <= p1_reg.job.length;
            pbyte_reg   <= p1_reg.job.use_mem ? rd_data_reg : '0;
            pindex_reg  <= p1_reg.idx;
            last_reg    <= p1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_reg.valid <= 1'b0;
            m_valid_reg  <= 1'b0;
            idx_reg      <= '0;
        end else begin
            if (p1_free) begin
                p1_reg.valid <= issue;
                p1_reg.job   <= q_job;
                p1_reg.idx   <= q_job.use_mem ? idx_reg : '0;
                p1_reg.last  <= issue_last;
            end
            if (advance) m_valid_reg <= p1_reg.valid;
            if (issue) idx_reg <= issue_last ? '0 : idx_reg + 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_command       = command_reg;
    assign m_device_id     = device_reg;
    assign m_length        = length_reg;
    assign m_payload_byte  = pbyte_reg;
    assign m_payload_index = pindex_reg;
    assign m_last          = last_reg;

    // Only good frames with a payload produce words that are not last.
    a_notlast_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !last_reg) |-> (status_reg == STATUS_GOOD))
        else $error("non-final word outside a good frame");

    // A payload position always lies inside the frame.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == STATUS_GOOD && length_reg != '0)
        |-> (pindex_reg < length_reg))
        else $error("payload index beyond length");

    // The final payload word sits at the last position of the frame.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && last_reg && status_reg == STATUS_GOOD && length_reg != '0)
        |-> (pindex_reg == length_reg - 1'b1))
        else $error("last word not at end of payload");

endmodule

// ===== hdl/actuator_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_frame_parser: start/header/payload frame parser with checksums
// Hunts for the start byte, checks header and data sums and emits one result
// word per payload byte, or one word for an empty or rejected frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Word
//   s_        in         s_valid / s_ready     rx_byte, one received byte
//   m_        out        m_valid / m_ready     status, command, device_id,
//                                              length, payload_byte,
//                                              payload_index, last
//   APB       in         psel/penable/pready   start_byte at address 0
//
// One input byte is taken per cycle. Results leave at one word per cycle
// once a frame has finished, while m_ready is high; the back end reads the
// two-bank payload buffer through its single registered read port, one
// byte per cycle. A new frame stalls at its first payload byte only while
// the bank it must fill still feeds results of a frame two back, and any
// byte stalls while the two-entry job queue is full.
// Reset (aresetn low at a clock edge) returns the parser to the start byte
// hunt, empties the queue and sets start_byte to 0x3E; no clearing pass.
// ----------------------------------------------------------------------------
module actuator_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_command,
    output logic [7:0]  m_device_id,
    output logic [5:0]  m_length,
    output logic [7:0]  m_payload_byte,
    output logic [5:0]  m_payload_index,
    output logic        m_last
);
    import afp_pkg::*;

    localparam logic REG_START = 1'b0;

    logic       start_reg;
    logic [7:0] start_byte_reg;
    logic       q_full, push, pop, q_valid;
    job_t       push_job, q_job;
    mem_wr_t    mem_wr;
    bank_rel_t  bank_rel;

    // The register lives at word 0; the upper word of the map reads as zero.
    assign start_reg = (paddr[2] == REG_START);
    assign pready    = 1'b1;
    assign prdata    = start_reg ? {24'd0, start_byte_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_BYTE_RESET;
        end else if (psel && penable && pwrite && pready && start_reg) begin
            start_byte_reg <= pwdata[7:0];
        end
    end

    afp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_byte (start_byte_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job),
        .mem_wr     (mem_wr),
        .bank_rel   (bank_rel)
    );

    afp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    afp_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .mem_wr          (mem_wr),
        .q_valid         (q_valid),
        .q_job           (q_job),
        .pop             (pop),
        .bank_rel        (bank_rel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_command       (m_command),
        .m_device_id     (m_device_id),
        .m_length        (m_length),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_last          (m_last)
    );

endmodule

// ===== sim/tb_actuator_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_actuator_frame_parser: self-checking bench for the actuator frame parser
// Feeds a directed byte script and then random framed traffic with line noise
// and corrupted sums, under three sender/receiver idling mixes and several
// start byte settings, and checks every result word against a local parser.
// ----------------------------------------------------------------------------
module tb_actuator_frame_parser;

    import afp_pkg::*;

    localparam logic [2:0] REG_START_BYTE   = 3'd0;
    localparam int         RANDOM_PER_PHASE = 115;
    localparam int         SETTLE_CYCLES    = 16;
    localparam int         DRAIN_CYCLES     = 32;
    localparam int         STALL_LIMIT      = 2000;

    typedef enum logic [2:0] {
        P_HUNT, P_CMD, P_ID, P_LEN, P_HSUM, P_DATA, P_DSUM
    } parse_phase_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] device_id;
        logic [IDX_W-1:0]  length;
        logic [BYTE_W-1:0] payload_byte;
        logic [IDX_W-1:0]  payload_index;
        logic              last;
    } frame_word_t;

    // One script byte; where typed is set, want is the word it must produce.
    typedef struct packed {
        logic [7:0]  rx;
        logic        typed;
        frame_word_t want;
    } script_row_t;

    localparam frame_word_t NO_WORD = '0;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_command;
    logic [7:0]  m_device_id;
    logic [5:0]  m_length;
    logic [7:0]  m_payload_byte;
    logic [5:0]  m_payload_index;
    logic        m_last;

    // Directed frames: over-limit length with extreme header bytes, empty good
    // frame, empty frame with a bad header sum, length one past the limit, and
    // a one-byte frame whose data byte equals the start byte.
    script_row_t script [0:24] = '{
        {8'h3E, 1'b0, NO_WORD},
        {8'hFF, 1'b0, NO_WORD},
        {8'h00, 1'b0, NO_WORD},
        {8'hFF, 1'b1, STATUS_LEN, 8'hFF, 8'h00, 6'h3F, 8'h00, 6'd0, 1'b1},
        {8'h3E, 1'b0, NO_WORD},
        {8'h00, 1'b0, NO_WORD},
        {8'hFF, 1'b0, NO_WORD},
        {8'h00, 1'b0, NO_WORD},
        {8'h3D, 1'b1, STATUS_GOOD, 8'h00, 8'hFF, 6'd0, 8'h00, 6'd0, 1'b1},
        {8'h3E, 1'b0, NO_WORD},
        {8'h12, 1'b0, NO_WORD},
        {8'h34, 1'b0, NO_WORD},
        {8'h00, 1'b0, NO_WORD},
        {8'h00, 1'b1, STATUS_CSUM, 8'h12, 8'h34, 6'd0, 8'h00, 6'd0, 1'b1},
        {8'h3E, 1'b0, NO_WORD},
        {8'hA5, 1'b0, NO_WORD},
        {8'h5A, 1'b0, NO_WORD},
        {8'h3D, 1'b1, STATUS_LEN, 8'hA5, 8'h5A, 6'h3D, 8'h00, 6'd0, 1'b1},
        {8'h3E, 1'b0, NO_WORD},
        {8'h01, 1'b0, NO_WORD},
        {8'h02, 1'b0, NO_WORD},
        {8'h01, 1'b0, NO_WORD},
        {8'h42, 1'b0, NO_WORD},
        {8'h3E, 1'b0, NO_WORD},
        {8'h3E, 1'b0, NO_WORD}
    };

    // Local parser state, mirrors the block's frame tracking.
    parse_phase_t parse_phase  = P_HUNT;
    logic [7:0]   start_sel    = START_BYTE_RESET;
    logic [7:0]   held_cmd     = '0;
    logic [7:0]   held_dev     = '0;
    logic [5:0]   held_len     = '0;
    logic [7:0]   got_hsum     = '0;
    logic [5:0]   write_pos    = '0;
    logic [7:0]   payload_copy [0:63];

    frame_word_t  fresh_words     [$];
    frame_word_t  frame_words_due [$];
    logic [7:0]   line_bytes      [$];
    logic         row_typed = 1'b0;
    frame_word_t  row_word  = '0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           fail_count  = 0;

    actuator_frame_parser u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_command       (m_command),
        .m_device_id     (m_device_id),
        .m_length        (m_length),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_last          (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task report_mismatch(input string what);
        fail_count++;
        $display("[%0t] %s", $time, what);
    endtask

    task check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
        end
    endtask

    function void emit(input logic [1:0] st, input logic [5:0] len, input logic [7:0] pb,
                       input logic [5:0] idx, input logic lst);
        fresh_words.push_back({st, held_cmd, held_dev, len, pb, idx, lst});
    endfunction

    // End of a frame: header sum first, then the data sum, then the payload.
    function void close_frame(input logic [7:0] dsum_rx);
        logic [7:0] hs;
        logic [7:0] ds;
        int         i;
        hs = start_sel + held_dev + held_cmd + held_len;
        if (hs != got_hsum) begin
            emit(STATUS_CSUM, held_len, 8'h00, 6'd0, 1'b1);
        end else if (held_len == 0) begin
            emit(STATUS_GOOD, 6'd0, 8'h00, 6'd0, 1'b1);
        end else begin
            ds = '0;
            for (i = 0; i < held_len; i++) begin
                ds = ds + payload_copy[i];
            end
            if (ds != dsum_rx) begin
                emit(STATUS_CSUM, held_len, 8'h00, 6'd0, 1'b1);
            end else begin
                for (i = 0; i < held_len; i++) begin
                    emit(STATUS_GOOD, held_len, payload_copy[i], i[5:0], (i + 1 == held_len));
                end
            end
        end
    endfunction

    function void parse_byte(input logic [7:0] b);
        case (parse_phase)
            P_CMD: begin
                held_cmd    = b;
                parse_phase = P_ID;
            end
            P_ID: begin
                held_dev    = b;
                parse_phase = P_LEN;
            end
            P_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    parse_phase = P_HUNT;
                    emit(STATUS_LEN, b[5:0], 8'h00, 6'd0, 1'b1);
                end else begin
                    held_len    = b[5:0];
                    write_pos   = '0;
                    parse_phase = P_HSUM;
                end
            end
            P_HSUM: begin
                got_hsum = b;
                if (held_len == 0) begin
                    parse_phase = P_HUNT;
                    close_frame(8'h00);
                end else begin
                    parse_phase = P_DATA;
                end
            end
            P_DATA: begin
                payload_copy[write_pos] = b;
                if (write_pos + 1 >= held_len) begin
                    parse_phase = P_DSUM;
                end else begin
                    write_pos = write_pos + 1'b1;
                end
            end
            P_DSUM: begin
                parse_phase = P_HUNT;
                close_frame(b);
            end
            default: begin
                parse_phase = (b == start_sel) ? P_CMD : P_HUNT;
            end
        endcase
    endfunction

    // Appends either a short burst of line noise or one frame. Lengths stay
    // small mostly; sums are corrupted now and then.
    function void queue_frame(input logic full);
        logic [7:0] cmd;
        logic [7:0] dev;
        logic [7:0] len;
        logic [7:0] hsum;
        logic [7:0] dsum;
        logic [7:0] d;
        int         n;
        if (!full && $urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) line_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        cmd = 8'($urandom_range(255));
        dev = 8'($urandom_range(255));
        case ($urandom_range(29))
            0:       len = 8'($urandom_range(255, MAX_PAYLOAD + 1));
            1:       len = 8'(MAX_PAYLOAD);
            2:       len = 8'($urandom_range(MAX_PAYLOAD, 9));
            default: len = 8'($urandom_range(8));
        endcase
        if (full) begin
            len = 8'(MAX_PAYLOAD);
        end
        hsum = start_sel + cmd + dev + len;
        if ($urandom_range(9) == 0) begin
            hsum = hsum ^ 8'($urandom_range(255, 1));
        end
        line_bytes.push_back(start_sel);
        line_bytes.push_back(cmd);
        line_bytes.push_back(dev);
        line_bytes.push_back(len);
        if (len > MAX_PAYLOAD) begin
            return;
        end
        line_bytes.push_back(hsum);
        if (len == 0) begin
            return;
        end
        dsum = '0;
        for (n = 0; n < len; n++) begin
            d    = 8'($urandom_range(255));
            dsum = dsum + d;
            line_bytes.push_back(d);
        end
        if ($urandom_range(9) == 0) begin
            dsum = dsum ^ 8'($urandom_range(255, 1));
        end
        line_bytes.push_back(dsum);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is
    // taken, leaving valid high so that it does not drop between back-to-back words.
    task push_byte(input logic [7:0] b, input logic typed, input frame_word_t want);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        row_typed <= typed;
        row_word  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task wait_drained;
        s_valid <= 1'b0;
        do @(negedge aclk); while (frame_words_due.size() != 0);
    endtask

    task apb_access(input logic wr, input logic [31:0] data, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= REG_START_BYTE;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Predicts on every accepted input word and checks every accepted result.
    always @(posedge aclk) begin : scoreboard
        frame_word_t got;
        frame_word_t want;
        if (aresetn && s_valid && s_ready) begin
            fresh_words.delete();
            parse_byte(s_rx_byte);
            if (row_typed) begin
                frame_words_due.push_back(row_word);
            end else begin
                foreach (fresh_words[i]) frame_words_due.push_back(fresh_words[i]);
            end
        end
        if (aresetn && m_valid && m_ready) begin
            got = {m_status, m_command, m_device_id, m_length,
                   m_payload_byte, m_payload_index, m_last};
            if (frame_words_due.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", got));
            end else begin
                want = frame_words_due.pop_front();
                check_field("status", got.status, want.status);
                check_field("command", got.command, want.command);
                check_field("device_id", got.device_id, want.device_id);
                check_field("length", got.length, want.length);
                check_field("payload_byte", got.payload_byte, want.payload_byte);
                check_field("payload_index", got.payload_index, want.payload_index);
                check_field("last", got.last, want.last);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("actuator_frame_parser: mismatch");
        $finish;
    end

    initial begin : stimulus
        logic [31:0] rd;
        logic [7:0]  start_val;
        logic        want_full;
        int          p;
        int          k;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = REG_START_BYTE;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_rx_byte = '0;
        want_full = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        apb_access(1'b0, 32'd0, rd);
        check_field("start_byte after reset", rd[7:0], START_BYTE_RESET);

        tx_idle_pct = 24;
        rx_idle_pct = 82;
        foreach (script[i]) push_byte(script[i].rx, script[i].typed, script[i].want);

        for (p = 0; p < 3; p++) begin
            // Only reprogram once all results are out and the parser is quiet.
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge aclk);
            case (p)
                0:       start_val = 8'h00;
                1:       start_val = 8'hFF;
                default: start_val = 8'($urandom_range(255));
            endcase
            apb_access(1'b1, {24'd0, start_val}, rd);
            start_sel = start_val;
            apb_access(1'b0, 32'd0, rd);
            check_field("start_byte readback", rd[7:0], start_val);

            case (p)
                0: begin
                    tx_idle_pct = 24;
                    rx_idle_pct = 82;
                end
                1: begin
                    tx_idle_pct = 82;
                    rx_idle_pct = 24;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    want_full   = 1'b1;
                end
            endcase

            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (line_bytes.size() == 0) begin
                    queue_frame(want_full);
                    want_full = 1'b0;
                end
                if (k == RANDOM_PER_PHASE / 2) begin
                    wait_drained();
                end
                push_byte(line_bytes.pop_front(), 1'b0, NO_WORD);
            end
        end

        s_valid <= 1'b0;
        while (frame_words_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("actuator_frame_parser: match");
        end else begin
            $display("actuator_frame_parser: mismatch");
        end
        $finish;
    end

endmodule

// ===== actuator_frame_parser.f =====
hdl/afp_pkg.sv
hdl/afp_front.sv
hdl/afp_queue.sv
hdl/afp_back.sv
hdl/actuator_frame_parser.sv
sim/tb_actuator_frame_parser.sv
